>>> src/sswag_pkg.sv
`default_nettype none
package sswag_pkg;

  localparam int unsigned MaxDimDef   = 4096;
  localparam int unsigned SineBitsDef = 10;

  localparam int unsigned SizeW  = 13;  // frame size registers
  localparam int unsigned CoordW = 12;  // pixel coordinates
  localparam int unsigned RegW   = 16;  // widest register
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned AmpPixW = 12; // amplitude in pixels, at most 2047 for MaxDimDef
  localparam int unsigned MagW   = 17;  // sine magnitude, Q1.16 up to 1.0
  localparam int unsigned PhNumW = 36;  // freq * pos * 256
  localparam int unsigned SrcNumW = 26; // |shifted coord * (size - 1)|

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 4'd0,
    REG_FRAME_HEIGHT = 4'd1,
    REG_AMP_X        = 4'd2,
    REG_AMP_Y        = 4'd3,
    REG_FREQ_X       = 4'd4,
    REG_FREQ_Y       = 4'd5,
    REG_PHASE_X      = 4'd6,
    REG_PHASE_Y      = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [CoordW-1:0] out_col;
    logic [CoordW-1:0] out_row;
  } in_t;

  typedef struct packed {
    logic [CoordW-1:0] src_col;
    logic [CoordW-1:0] src_row;
    logic              inside_res;
  } out_t;

  // Long division by shift and subtract, used only while building the table.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave entry sin(pi/2 * i / 2^bits), Q1.16, Taylor series in Q2.30.
  function automatic logic [MagW-1:0] sine_entry(input int unsigned i,
                                                 input int unsigned bits);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] div;
    longint      sum;
    longint      r;
    x = (64'd1686629713 * 64'(i) + (64'd1 << (bits - 1))) >> bits;
    sum = longint'(x);
    term = x;
    for (int k = 1; k <= 10; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      div  = 64'(2 * k) * 64'(2 * k + 1);
      term = udiv64(term, div);
      if ((k % 2) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum + 64'sd8192) >>> 14;
    if (r > 65536) r = 65536;
    return MagW'(r);
  endfunction

endpackage
`default_nettype wire

>>> src/sswag_div.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
module sswag_div import sswag_pkg::*; #(
  parameter int unsigned NW = 26,
  parameter int unsigned DW = 13,
  parameter int unsigned SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic      [NW-1:0] quo_o,
  output logic      [SW-1:0] side_o
);

  logic [DW+NW-1:0] acc_q [NW];
  logic [SW-1:0]    side_q [NW];

  function automatic logic [DW+NW-1:0] div_step(input logic [DW+NW-1:0] a,
                                                input logic [DW-1:0] d);
    logic [DW+NW:0] s;
    logic [DW:0]    top;
    logic           ge;
    s   = {a, 1'b0};
    top = s[DW+NW:NW];
    ge  = top >= {1'b0, d};
    if (ge) top = top - {1'b0, d};
    return {top[DW-1:0], s[NW-1:1], ge};
  endfunction

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW+NW-1:0] acc_in;
    logic [SW-1:0]    side_in;
    if (i == 0) begin : g_first
      assign acc_in  = {{DW{1'b0}}, num_i};
      assign side_in = side_i;
    end else begin : g_next
      assign acc_in  = acc_q[i-1];
      assign side_in = side_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[i]  <= div_step(acc_in, den_i);
        side_q[i] <= side_in;
      end
    end
  end

  assign quo_o  = acc_q[NW-1][NW-1:0];
  assign side_o = side_q[NW-1];

endmodule
`default_nettype wire

>>> src/sine_wave_warp_address_gen_unit.sv
`default_nettype none
// Channel   Handshake               Payload
// in        in_valid_i / in_ready_o   in_data_i  (out_col, out_row)
// out       out_valid_o / out_ready_i out_data_o (src_col, src_row, inside_res)
// cfg       cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One transaction per clock while the output is not stalled; 69 register stages:
// two bit-per-stage dividers (36 phase, 26 stretch) plus
// seven arithmetic and ROM stages.
// A stalled output holds the whole pipe and deasserts in_ready_o; nothing drops.
// Reset clears valid bits and loads register defaults; derived amplitude terms
// are registered in turn as product, pixel amplitude and divisor after a write.
module sine_wave_warp_address_gen_unit import sswag_pkg::*; #(
  parameter int unsigned MAX_DIM         = MaxDimDef,
  parameter int unsigned SINE_TABLE_BITS = SineBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_t                in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_t                    out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [RegW-1:0]    cfg_data_i
);

  localparam int unsigned SineN  = 1 << SINE_TABLE_BITS;
  localparam int unsigned FullW  = SINE_TABLE_BITS + 2;
  localparam int unsigned AddrW  = SINE_TABLE_BITS + 1;
  localparam int unsigned PhShift = 14 - SINE_TABLE_BITS;
  localparam int unsigned PhHalf = (PhShift > 0) ? (1 << (PhShift - 1)) : 0;

  // stage map
  localparam int unsigned StMul  = 0;
  localparam int unsigned StPh   = StMul + PhNumW + 1;
  localparam int unsigned StRom  = StPh + 1;
  localparam int unsigned StShf  = StRom + 1;
  localparam int unsigned StOff  = StShf + 1;
  localparam int unsigned StProd = StOff + 1;
  localparam int unsigned StOut  = StProd + SrcNumW + 1;
  localparam int unsigned NumSt  = StOut + 1;

  typedef logic [MagW-1:0] rom_t [SineN];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < SineN; i++) r[i] = sine_entry(i, SINE_TABLE_BITS);
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  // ---------------- configuration ----------------
  logic [SizeW-1:0] width_q, height_q;
  logic [RegW-1:0]  amp_x_q, amp_y_q, freq_x_q, freq_y_q, phase_x_q, phase_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 13'd640;
      height_q  <= 13'd480;
      amp_x_q   <= 16'd983;
      amp_y_q   <= 16'd983;
      freq_x_q  <= 16'd1024;
      freq_y_q  <= 16'd1024;
      phase_x_q <= '0;
      phase_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  width_q   <= cfg_data_i[SizeW-1:0];
        REG_FRAME_HEIGHT: height_q  <= cfg_data_i[SizeW-1:0];
        REG_AMP_X:        amp_x_q   <= cfg_data_i;
        REG_AMP_Y:        amp_y_q   <= cfg_data_i;
        REG_FREQ_X:       freq_x_q  <= cfg_data_i;
        REG_FREQ_Y:       freq_y_q  <= cfg_data_i;
        REG_PHASE_X:      phase_x_q <= cfg_data_i;
        REG_PHASE_Y:      phase_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
    if (v < SizeW'(2)) return SizeW'(2);
    if (32'(v) > 32'(MAX_DIM)) return SizeW'(MAX_DIM);
    return v;
  endfunction

  logic [SizeW-1:0] w_sz, h_sz;
  assign w_sz = clamp_size(width_q);
  assign h_sz = clamp_size(height_q);

  // amplitude in pixels: amp * size / 32768, rounded, clamped to (size>>1)-1
  logic [RegW+SizeW-1:0] pax_q, pay_q;
  logic [AmpPixW-1:0]    ax_q, ay_q;
  logic [SizeW-1:0]      ddx_q, ddy_q;   // size - 2*amp - 1

  function automatic logic [AmpPixW-1:0] amp_pix(input logic [RegW+SizeW-1:0] p,
                                                 input logic [SizeW-1:0] sz);
    logic [RegW+SizeW:0] r;
    logic [SizeW-1:0]    hi;
    logic [RegW+SizeW-15:0] a;
    r  = {1'b0, p} + (RegW+SizeW+1)'(16384);
    a  = r[RegW+SizeW:15];
    hi = (sz >> 1) - SizeW'(1);
    if (a > (RegW+SizeW-14)'(hi)) a = (RegW+SizeW-14)'(hi);
    return AmpPixW'(a);
  endfunction

  always_ff @(posedge clk_i) begin
    pax_q <= amp_x_q * w_sz;
    pay_q <= amp_y_q * h_sz;
    ax_q  <= amp_pix(pax_q, w_sz);
    ay_q  <= amp_pix(pay_q, h_sz);
    ddx_q <= w_sz - {ax_q, 1'b0} - SizeW'(1);
    ddy_q <= h_sz - {ay_q, 1'b0} - SizeW'(1);
  end

  // ---------------- pipeline control ----------------
  logic              en;
  logic [NumSt-1:0]  valid_q;

  assign en          = !valid_q[NumSt-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[NumSt-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NumSt-2:0], in_valid_i};
    end
  end

  // ---------------- stage: phase products ----------------
  logic [RegW+CoordW-1:0] nfx_q, nfy_q;
  logic [CoordW-1:0]      col0_q, row0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nfx_q  <= freq_x_q * in_data_i.out_row;
      nfy_q  <= freq_y_q * in_data_i.out_col;
      col0_q <= in_data_i.out_col;
      row0_q <= in_data_i.out_row;
    end
  end

  // ---------------- phase dividers ----------------
  logic [PhNumW-1:0] phqx, phqy;
  logic [CoordW-1:0] col1, row1;

  sswag_div #(.NW(PhNumW), .DW(SizeW), .SW(CoordW)) u_phdiv_x (
    .clk_i, .en_i(en), .num_i({nfx_q, 8'd0}), .den_i(h_sz),
    .side_i(col0_q), .quo_o(phqx), .side_o(col1)
  );

  sswag_div #(.NW(PhNumW), .DW(SizeW), .SW(CoordW)) u_phdiv_y (
    .clk_i, .en_i(en), .num_i({nfy_q, 8'd0}), .den_i(w_sz),
    .side_i(row0_q), .quo_o(phqy), .side_o(row1)
  );

  // ---------------- stage: table address ----------------
  function automatic logic [FullW-1:0] phase_full(input logic [15:0] q,
                                                  input logic [15:0] ph0);
    logic [15:0] ph;
    logic [16:0] s;
    ph = q + ph0;
    s  = {1'b0, ph} + 17'(PhHalf);
    return s[PhShift +: FullW];
  endfunction

  function automatic logic [AddrW-1:0] rom_addr(input logic [FullW-1:0] f);
    logic [SINE_TABLE_BITS-1:0] idx;
    idx = f[SINE_TABLE_BITS-1:0];
    if (f[SINE_TABLE_BITS]) return AddrW'(SineN) - {1'b0, idx};
    return {1'b0, idx};
  endfunction

  logic [FullW-1:0]  fx, fy;
  logic [AddrW-1:0]  addrx_q, addry_q;
  logic              negx2_q, negy2_q;
  logic [CoordW-1:0] col2_q, row2_q;

  assign fx = phase_full(phqx[15:0], phase_x_q);
  assign fy = phase_full(phqy[15:0], phase_y_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      addrx_q <= rom_addr(fx);
      addry_q <= rom_addr(fy);
      negx2_q <= fx[FullW-1];
      negy2_q <= fy[FullW-1];
      col2_q  <= col1;
      row2_q  <= row1;
    end
  end

  // ---------------- stage: sine ROM ----------------
  logic [MagW-1:0]   magx_q, magy_q;
  logic              negx3_q, negy3_q;
  logic [CoordW-1:0] col3_q, row3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // top address bit set only for the exact quarter point, which is 1.0
      magx_q  <= addrx_q[AddrW-1] ? MagW'(65536) : SineRom[addrx_q[AddrW-2:0]];
      magy_q  <= addry_q[AddrW-1] ? MagW'(65536) : SineRom[addry_q[AddrW-2:0]];
      negx3_q <= negx2_q;
      negy3_q <= negy2_q;
      col3_q  <= col2_q;
      row3_q  <= row2_q;
    end
  end

  // ---------------- stage: wave shift ----------------
  function automatic logic signed [AmpPixW:0] wave(input logic [AmpPixW-1:0] a,
                                                   input logic [MagW-1:0] m,
                                                   input logic neg);
    logic [AmpPixW+MagW:0] p;
    logic [AmpPixW-1:0]    r;
    p = (AmpPixW+MagW+1)'(a) * (AmpPixW+MagW+1)'(m) + (AmpPixW+MagW+1)'(32768);
    r = p[16 +: AmpPixW];
    return neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  logic signed [AmpPixW:0] dx_q, dy_q;
  logic [CoordW-1:0]       col4_q, row4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q   <= wave(ax_q, magx_q, negx3_q);
      dy_q   <= wave(ay_q, magy_q, negy3_q);
      col4_q <= col3_q;
      row4_q <= row3_q;
    end
  end

  // ---------------- stage: offset coordinate ----------------
  logic signed [SizeW:0] tx_q, ty_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tx_q <= $signed({2'b00, col4_q}) + (SizeW+1)'(dx_q) - $signed({2'b00, ax_q});
      ty_q <= $signed({2'b00, row4_q}) + (SizeW+1)'(dy_q) - $signed({2'b00, ay_q});
    end
  end

  // ---------------- stage: stretch product ----------------
  function automatic logic [SizeW-1:0] abs_t(input logic signed [SizeW:0] t);
    logic signed [SizeW:0] a;
    a = t[SizeW] ? -t : t;
    return a[SizeW-1:0];
  endfunction

  logic [SrcNumW-1:0] prx_q, pry_q;
  logic               sgx_q, sgy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prx_q <= abs_t(tx_q) * (w_sz - SizeW'(1));
      pry_q <= abs_t(ty_q) * (h_sz - SizeW'(1));
      sgx_q <= tx_q[SizeW];
      sgy_q <= ty_q[SizeW];
    end
  end

  // ---------------- stretch dividers ----------------
  logic [SrcNumW-1:0] sqx, sqy;
  logic               sgx, sgy;

  sswag_div #(.NW(SrcNumW), .DW(SizeW), .SW(1)) u_srcdiv_x (
    .clk_i, .en_i(en), .num_i(prx_q), .den_i(ddx_q),
    .side_i(sgx_q), .quo_o(sqx), .side_o(sgx)
  );

  sswag_div #(.NW(SrcNumW), .DW(SizeW), .SW(1)) u_srcdiv_y (
    .clk_i, .en_i(en), .num_i(pry_q), .den_i(ddy_q),
    .side_i(sgy_q), .quo_o(sqy), .side_o(sgy)
  );

  // ---------------- stage: frame check and output ----------------
  // truncation toward zero: a negative numerator with zero quotient gives 0
  logic in_x, in_y, in_frame;
  assign in_x     = (sqx == '0) || (!sgx && (sqx < SrcNumW'(w_sz)));
  assign in_y     = (sqy == '0) || (!sgy && (sqy < SrcNumW'(h_sz)));
  assign in_frame = in_x && in_y;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o.src_col    <= in_frame ? sqx[CoordW-1:0] : '0;
      out_data_o.src_row    <= in_frame ? sqy[CoordW-1:0] : '0;
      out_data_o.inside_res <= in_frame;
    end
  end

endmodule
`default_nettype wire

>>> verif/sine_wave_warp_address_gen_unit_tb.sv
`timescale 1ns / 1ps
module sine_wave_warp_address_gen_unit_tb;
  import sswag_pkg::*;

  localparam int unsigned QuarterN  = 1 << SineBitsDef;
  localparam longint      SineOne   = 65536;
  localparam int unsigned CycleCap  = 1_000_000;
  localparam int unsigned DrainWait = 80;   // pipe depth is 69
  localparam int unsigned HoldOff   = 400;  // long output stall, fills the pipe
  // Index past the register file; the block must ignore the write.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 4'd9;

  // Warp address predictor plus the queue of expected source addresses.
  class warp_scoreboard;
    logic [RegW-1:0] regs [8];
    longint          quarter_sine [QuarterN];
    out_t            expected_addrs [$];
    int              errors;

    function new();
      logic [63:0] x;
      logic [63:0] term;
      longint      acc;
      longint      r;
      for (int i = 0; i < QuarterN; i++) begin
        x = (64'd1686629713 * 64'(i) + 64'(QuarterN / 2)) / 64'(QuarterN);
        acc = longint'(x);
        term = x;
        for (int k = 1; k <= 10; k++) begin
          term = (term * x) >> 30;
          term = (term * x) >> 30;
          term = term / (64'(2 * k) * 64'(2 * k + 1));
          acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        r = (acc + 8192) >>> 14;
        quarter_sine[i] = (r > SineOne) ? SineOne : r;
      end
      regs[REG_FRAME_WIDTH]  = 640;
      regs[REG_FRAME_HEIGHT] = 480;
      regs[REG_AMP_X]        = 983;
      regs[REG_AMP_Y]        = 983;
      regs[REG_FREQ_X]       = 1024;
      regs[REG_FREQ_Y]       = 1024;
      regs[REG_PHASE_X]      = 0;
      regs[REG_PHASE_Y]      = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] v);
      if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) regs[idx[2:0]] = v & 16'h1FFF;
      else if (idx <= REG_PHASE_Y) regs[idx[2:0]] = v;
    endfunction

    function longint dim(cfg_idx_e idx);
      longint v;
      v = longint'(regs[idx]);
      if (v < 2) return 2;
      if (v > MaxDimDef) return MaxDimDef;
      return v;
    endfunction

    function longint amp_pixels(longint frac, longint size);
      longint a;
      a = (frac * size + 16384) >>> 15;
      if (a > (size >>> 1) - 1) a = (size >>> 1) - 1;
      return (a < 0) ? 0 : a;
    endfunction

    function longint wave_offset(longint amp, longint freq, longint pos, longint span,
                                 longint phase);
      longint      turns;
      logic [15:0] ph;
      logic [11:0] full;
      logic [1:0]  quad;
      int          idx;
      longint      mag;
      longint      m;
      turns = (freq * pos * 256) / span;
      ph = 16'(turns + phase);
      full = 12'((17'(ph) + 17'd8) >> 4);   // round 16-bit turn to table grid
      quad = full[11:10];
      idx = int'(full[9:0]);
      if (quad[0]) mag = (idx == 0) ? SineOne : quarter_sine[QuarterN - idx];
      else         mag = quarter_sine[idx];
      m = (amp * mag + 32768) >>> 16;
      return quad[1] ? -m : m;
    endfunction

    function void note(in_t px);
      longint w, h, ax, ay, dx, dy, sx, sy, col, row;
      out_t   e;
      col = longint'(px.out_col);
      row = longint'(px.out_row);
      w  = dim(REG_FRAME_WIDTH);
      h  = dim(REG_FRAME_HEIGHT);
      ax = amp_pixels(longint'(regs[REG_AMP_X]), w);
      ay = amp_pixels(longint'(regs[REG_AMP_Y]), h);
      dx = wave_offset(ax, longint'(regs[REG_FREQ_X]), row, h, longint'(regs[REG_PHASE_X]));
      dy = wave_offset(ay, longint'(regs[REG_FREQ_Y]), col, w, longint'(regs[REG_PHASE_Y]));
      sx = ((col + dx - ax) * (w - 1)) / (w - 2 * ax - 1);
      sy = ((row + dy - ay) * (h - 1)) / (h - 2 * ay - 1);
      e.inside_res = (sx >= 0 && sx < w && sy >= 0 && sy < h);
      e.src_col = e.inside_res ? CoordW'(sx) : '0;
      e.src_row = e.inside_res ? CoordW'(sy) : '0;
      expected_addrs.push_back(e);
    endfunction

    function void check(out_t got);
      out_t e;
      if (expected_addrs.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = expected_addrs.pop_front();
      if (got.src_col !== e.src_col) begin
        $display("%0t: src_col expected %0d actual %0d", $time, e.src_col, got.src_col);
        errors++;
      end
      if (got.src_row !== e.src_row) begin
        $display("%0t: src_row expected %0d actual %0d", $time, e.src_row, got.src_row);
        errors++;
      end
      if (got.inside_res !== e.inside_res) begin
        $display("%0t: inside_res expected %0b actual %0b", $time, e.inside_res,
                 got.inside_res);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  in_t                in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_t               out_data_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [RegW-1:0]    cfg_data_i;

  warp_scoreboard addr_board = new();
  bit             bursts_on = 1;   // random idling on both channels
  bit             hold_req  = 0;   // asks the receiver for one long stall
  int unsigned    cycle_count = 0;

  sine_wave_warp_address_gen_unit dut (.*);

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  // Cycle budget; a stuck handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleCap) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Monitor: every accepted transaction is seen at the edge that accepts it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) addr_board.note(in_data_i);
      if (out_valid_o && out_ready_i) addr_board.check(out_data_o);
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        for (int n = 0; n < HoldOff; n++) @(posedge clk_i);
        hold_req = 0;
      end else if (bursts_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Offer one pixel; returns on the edge that accepts it.
  task automatic send_pixel(logic [CoordW-1:0] col, logic [CoordW-1:0] row);
    bit took;
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{out_col: col, out_row: row};
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  // Drop valid, let the pipe empty, then let it settle for a register write.
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (addr_board.expected_addrs.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // One write, then the enable goes low again before the task returns.
  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    addr_board.write_reg(idx, v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_cfg(logic [RegW-1:0] w, logic [RegW-1:0] h, logic [RegW-1:0] ax,
                          logic [RegW-1:0] ay, logic [RegW-1:0] fx, logic [RegW-1:0] fy,
                          logic [RegW-1:0] px, logic [RegW-1:0] py);
    drain_pipe();
    write_cfg(REG_FRAME_WIDTH, w);
    write_cfg(REG_FRAME_HEIGHT, h);
    write_cfg(REG_AMP_X, ax);
    write_cfg(REG_AMP_Y, ay);
    write_cfg(REG_FREQ_X, fx);
    write_cfg(REG_FREQ_Y, fy);
    write_cfg(REG_PHASE_X, px);
    write_cfg(REG_PHASE_Y, py);
    repeat (4) @(posedge clk_i);   // amplitude terms settle after a write
  endtask

  // Mostly pixels inside the current frame, some anywhere in the 12-bit range.
  task automatic random_pixels(int count);
    longint w, h;
    w = addr_board.dim(REG_FRAME_WIDTH);
    h = addr_board.dim(REG_FRAME_HEIGHT);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) != 0)
        send_pixel(CoordW'($urandom_range(0, w - 1)), CoordW'($urandom_range(0, h - 1)));
      else
        send_pixel(CoordW'($urandom), CoordW'($urandom));
    end
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // Reset defaults: corners, frame edges, pixels past the frame.
    send_pixel(0, 0);
    send_pixel(639, 479);
    send_pixel(0, 479);
    send_pixel(639, 0);
    send_pixel(320, 240);
    send_pixel(640, 480);
    send_pixel(4095, 4095);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    for (int r = 0; r < 8; r++) send_pixel(CoordW'(r * 80), CoordW'(r * 60));
    hold_req = 1;   // back pressure while the sender keeps offering
    random_pixels(240);

    // Smallest frame, largest amplitude, frequency and phase.
    load_cfg(2, 2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(0, 0);
    send_pixel(1, 1);
    send_pixel(2, 2);
    random_pixels(150);

    // Largest frame with zero amplitude: identity warp.
    load_cfg(4096, 4096, 0, 0, 0, 0, 0, 0);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    random_pixels(200);

    // Sizes out of range saturate; upper data bits fall outside the register.
    load_cfg(16'hFFFF, 0, 16'h8000, 16'h4000, 16'h0100, 16'h0080, 16'h4000, 16'hC000);
    write_cfg(CfgIdxSpare, 16'h0005);
    random_pixels(200);
    load_cfg(1, 16'h3000, 16'h7FFF, 16'h2000, 16'h0300, 16'h0500, 16'h8000, 16'h0001);
    random_pixels(200);

    // Random settings with small frames, 2 to 700 per side.
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) bursts_on = 0;
      load_cfg(16'($urandom_range(2, 700)), 16'($urandom_range(2, 700)), 16'($urandom),
               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      random_pixels(230);
    end

    in_valid_i <= 1'b0;
    while (addr_board.expected_addrs.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (addr_board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
